### sv/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included by files that check their own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### sv/pse_pkg.sv
// types, constants and token decode for the postfix stack evaluator
// no dependencies; used by every module of the block
package pse_pkg;

  localparam int unsigned DW          = 32;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned AW          = $clog2(STACK_DEPTH);
  localparam int unsigned CW          = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW          = $clog2(DW);

  localparam logic [CW-1:0] CNT_TWO   = CW'(2);
  localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);
  localparam logic [SW-1:0] LAST_STEP = SW'(DW - 1);

  localparam logic [7:0] TOK_ADD = 8'h2B;
  localparam logic [7:0] TOK_SUB = 8'h2D;
  localparam logic [7:0] TOK_MUL = 8'h2A;
  localparam logic [7:0] TOK_DIV = 8'h2F;
  localparam logic [7:0] TOK_POW = 8'h5E;
  localparam logic [7:0] TOK_REM = 8'h25;

  localparam logic [DW-1:0] OPERAND_BIAS = DW'(48);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_DIV_ZERO  = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM,
    OP_POW
  } alu_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIV,
    ALU_POW,
    ALU_SIGN
  } alu_state_e;

  typedef struct packed {
    logic [7:0] token;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    logic          rd_en;
    logic          push;
    logic          pop;
    logic          clear;
    logic [DW-1:0] wdata;
  } stack_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic logic is_operator(input logic [7:0] tok);
    logic hit;
    case (tok) inside
      TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_POW, TOK_REM: hit = 1'b1;
      default:                                              hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic alu_op_e tok_to_op(input logic [7:0] tok);
    alu_op_e op;
    unique case (tok)
      TOK_SUB: op = OP_SUB;
      TOK_MUL: op = OP_MUL;
      TOK_DIV: op = OP_DIV;
      TOK_REM: op = OP_REM;
      TOK_POW: op = OP_POW;
      default: op = OP_ADD;
    endcase
    return op;
  endfunction

endpackage

### sv/pse_stack.sv
// operand stack: top value in a register, deeper values in a memory
// depends on pse_pkg
module pse_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pse_pkg::stack_cmd_t         cmd_i,
  output logic [pse_pkg::DW-1:0]      tos_o,
  output logic [pse_pkg::DW-1:0]      below_o,
  output logic [pse_pkg::CW-1:0]      count_o
);

  logic [pse_pkg::DW-1:0] mem_q [pse_pkg::STACK_DEPTH];
  logic [pse_pkg::DW-1:0] tos_q;
  logic [pse_pkg::DW-1:0] below_q;
  logic [pse_pkg::CW-1:0] count_q, count_d;
  logic [pse_pkg::CW-1:0] cnt_m1, cnt_m2;
  logic [pse_pkg::AW-1:0] wr_idx, rd_idx;

  assign cnt_m1 = count_q - pse_pkg::CW'(1);
  assign cnt_m2 = count_q - pse_pkg::CNT_TWO;
  assign wr_idx = cnt_m1[pse_pkg::AW-1:0];
  assign rd_idx = cnt_m2[pse_pkg::AW-1:0];

  // old top moves into the memory on a push
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (count_q != '0)) begin
      mem_q[wr_idx] <= tos_q;
    end
    if (cmd_i.rd_en) begin
      below_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.pop) begin
      tos_q <= cmd_i.wdata;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + pse_pkg::CW'(1);
    end else if (cmd_i.pop) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign tos_o   = tos_q;
  assign below_o = below_q;
  assign count_o = count_q;

endmodule

### sv/pse_alu.sv
// shared arithmetic unit: add, sub, mul registered on start; iterative divide, remainder and power
// depends on pse_pkg
module pse_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  pse_pkg::alu_op_e        op_i,
  input  logic [pse_pkg::DW-1:0]  lhs_i,
  input  logic [pse_pkg::DW-1:0]  rhs_i,
  output pse_pkg::alu_stat_t      stat_o,
  output logic [pse_pkg::DW-1:0]  result_o
);

  pse_pkg::alu_state_e state_q, state_d;
  pse_pkg::alu_op_e    op_q;
  logic                done_q, done_d;
  logic                neg_q;
  logic [pse_pkg::DW-1:0] x_q, y_q, result_q;
  logic [pse_pkg::DW:0]   z_q;
  logic [pse_pkg::SW-1:0] step_q;

  logic [pse_pkg::DW-1:0] mul_a, mul_b, prod, sq;
  logic [pse_pkg::DW-1:0] lhs_abs, rhs_abs;
  logic [pse_pkg::DW:0]   rem_sh, rem_nx;
  logic                   ge;
  logic                   exp_zero;

  // multiplier takes operands directly on start, loop registers otherwise
  assign mul_a = (state_q == pse_pkg::ALU_IDLE) ? lhs_i : x_q;
  assign mul_b = (state_q == pse_pkg::ALU_IDLE) ? rhs_i : y_q;
  assign prod  = mul_a * mul_b;
  assign sq    = y_q * y_q;

  assign lhs_abs = lhs_i[pse_pkg::DW-1] ? (~lhs_i + 1'b1) : lhs_i;
  assign rhs_abs = rhs_i[pse_pkg::DW-1] ? (~rhs_i + 1'b1) : rhs_i;

  // restoring divide step on magnitudes
  assign rem_sh = {z_q[pse_pkg::DW-1:0], x_q[pse_pkg::DW-1]};
  assign ge     = rem_sh >= {1'b0, y_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, y_q}) : rem_sh;

  assign exp_zero = (z_q[pse_pkg::DW-1:0] == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::ALU_IDLE: begin
        if (start_i) begin
          if ((op_i == pse_pkg::OP_DIV) || (op_i == pse_pkg::OP_REM)) begin
            state_d = pse_pkg::ALU_DIV;
          end else if ((op_i == pse_pkg::OP_POW) && !rhs_i[pse_pkg::DW-1]) begin
            state_d = pse_pkg::ALU_POW;
          end
        end
      end
      pse_pkg::ALU_DIV: begin
        if (step_q == pse_pkg::LAST_STEP) begin
          state_d = pse_pkg::ALU_SIGN;
        end
      end
      pse_pkg::ALU_POW: begin
        if (exp_zero) begin
          state_d = pse_pkg::ALU_IDLE;
        end
      end
      pse_pkg::ALU_SIGN: state_d = pse_pkg::ALU_IDLE;
      default:           state_d = pse_pkg::ALU_IDLE;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    unique case (state_q)
      pse_pkg::ALU_IDLE: begin
        if (start_i) begin
          done_d = !((op_i == pse_pkg::OP_DIV) || (op_i == pse_pkg::OP_REM) ||
                     ((op_i == pse_pkg::OP_POW) && !rhs_i[pse_pkg::DW-1]));
        end
      end
      pse_pkg::ALU_POW:  done_d = exp_zero;
      pse_pkg::ALU_SIGN: done_d = 1'b1;
      default:           done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ALU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pse_pkg::ALU_IDLE: begin
        if (start_i) begin
          op_q <= op_i;
          case (op_i) inside
            pse_pkg::OP_ADD: result_q <= lhs_i + rhs_i;
            pse_pkg::OP_SUB: result_q <= lhs_i - rhs_i;
            pse_pkg::OP_MUL: result_q <= prod;
            pse_pkg::OP_DIV, pse_pkg::OP_REM: begin
              x_q    <= lhs_abs;
              y_q    <= rhs_abs;
              z_q    <= '0;
              step_q <= '0;
              neg_q  <= (op_i == pse_pkg::OP_DIV) ?
                        (lhs_i[pse_pkg::DW-1] ^ rhs_i[pse_pkg::DW-1]) :
                        lhs_i[pse_pkg::DW-1];
            end
            default: begin
              // power: negative exponent ends here with 1
              x_q      <= pse_pkg::DW'(1);
              y_q      <= lhs_i;
              z_q      <= {1'b0, rhs_i};
              result_q <= pse_pkg::DW'(1);
            end
          endcase
        end
      end
      pse_pkg::ALU_DIV: begin
        x_q    <= {x_q[pse_pkg::DW-2:0], ge};
        z_q    <= rem_nx;
        step_q <= step_q + 1'b1;
      end
      pse_pkg::ALU_POW: begin
        if (exp_zero) begin
          result_q <= x_q;
        end else begin
          if (z_q[0]) begin
            x_q <= prod;
          end
          y_q <= sq;
          z_q <= z_q >> 1;
        end
      end
      default: begin
        if (op_q == pse_pkg::OP_DIV) begin
          result_q <= neg_q ? (~x_q + 1'b1) : x_q;
        end else begin
          result_q <= neg_q ? (~z_q[pse_pkg::DW-1:0] + 1'b1) : z_q[pse_pkg::DW-1:0];
        end
      end
    endcase
  end

  assign stat_o.busy = (state_q != pse_pkg::ALU_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = result_q;

endmodule

### sv/postfix_stack_evaluator.sv
// Postfix expression evaluator, top level.
// One byte token per request on the input channel (in_valid_i/in_ready_o);
// operator bytes + - * / ^ % combine the two top stack values, any other byte
// pushes (byte - 48). A request with last set ends the expression and gives
// one result request on the output channel: the top value (0 if the stack
// is empty or an error occurred) and a status (ok, underflow, divide by
// zero, overflow). The first error is sticky and later tokens are ignored
// until the last one. Operands, ignored tokens and tokens that raise an
// error pass through the decode and finish states; add/sub/mul and power
// with a negative exponent also wait in the run state for the shared unit,
// divide and remainder for its 32-step restoring loop, and any other power
// for its square-and-multiply loop over the exponent bits.
// The block takes one token at a time and is not ready while it works on
// it. A finished result sits in an output register, so the next expression
// may start while it waits; a last token that finds the register still full
// holds until the receiver takes it. Reset empties the stack, clears the
// error and drops any pending result.
// Depends on pse_pkg, pse_stack, pse_alu and assert_macros.svh.
`include "assert_macros.svh"

module postfix_stack_evaluator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pse_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pse_pkg::out_item_t  out_item_o
);

  pse_pkg::state_e     state_q, state_d;
  pse_pkg::status_e    err_q, err_d;
  logic [7:0]          tok_q;
  logic                last_q;
  logic                out_valid_q;
  pse_pkg::out_item_t  out_item_q;

  pse_pkg::stack_cmd_t    cmd;
  logic [pse_pkg::DW-1:0] tos, below;
  logic [pse_pkg::CW-1:0] count;
  pse_pkg::alu_stat_t     alu_stat;
  logic [pse_pkg::DW-1:0] alu_result;
  logic                   alu_start;
  pse_pkg::alu_op_e       alu_op;

  logic accept, tok_op, div_like, go_alu, slot_free, out_load;

  assign accept    = in_valid_i && in_ready_o;
  assign tok_op    = pse_pkg::is_operator(tok_q);
  assign alu_op    = pse_pkg::tok_to_op(tok_q);
  assign div_like  = (alu_op == pse_pkg::OP_DIV) || (alu_op == pse_pkg::OP_REM);
  assign go_alu    = (err_q == pse_pkg::STATUS_OK) && tok_op && (count >= pse_pkg::CNT_TWO) &&
                     !(div_like && (tos == '0));
  assign slot_free = !out_valid_q || out_ready_i;

  pse_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .tos_o   (tos),
    .below_o (below),
    .count_o (count)
  );

  // deeper value is the left operand
  pse_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (alu_start),
    .op_i     (alu_op),
    .lhs_i    (below),
    .rhs_i    (tos),
    .stat_o   (alu_stat),
    .result_o (alu_result)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pse_pkg::ST_DECODE;
        end
      end
      pse_pkg::ST_DECODE: state_d = go_alu ? pse_pkg::ST_RUN : pse_pkg::ST_FINISH;
      pse_pkg::ST_RUN: begin
        if (alu_stat.done) begin
          state_d = pse_pkg::ST_FINISH;
        end
      end
      pse_pkg::ST_FINISH: begin
        if (!last_q || slot_free) begin
          state_d = pse_pkg::ST_IDLE;
        end
      end
      default: state_d = pse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd        = '0;
    alu_start  = 1'b0;
    err_d      = err_q;
    out_load   = 1'b0;
    unique case (state_q)
      pse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        // fetch the value below the top while the token is taken
        cmd.rd_en  = in_valid_i;
      end
      pse_pkg::ST_DECODE: begin
        if (err_q == pse_pkg::STATUS_OK) begin
          if (tok_op) begin
            if (count < pse_pkg::CNT_TWO) begin
              err_d = pse_pkg::STATUS_UNDERFLOW;
            end else if (div_like && (tos == '0)) begin
              err_d = pse_pkg::STATUS_DIV_ZERO;
            end else begin
              alu_start = 1'b1;
            end
          end else if (count == pse_pkg::CNT_FULL) begin
            err_d = pse_pkg::STATUS_OVERFLOW;
          end else begin
            cmd.push  = 1'b1;
            cmd.wdata = {{(pse_pkg::DW-8){1'b0}}, tok_q} - pse_pkg::OPERAND_BIAS;
          end
        end
      end
      pse_pkg::ST_RUN: begin
        if (alu_stat.done) begin
          cmd.pop   = 1'b1;
          cmd.wdata = alu_result;
        end
      end
      pse_pkg::ST_FINISH: begin
        if (last_q && slot_free) begin
          out_load  = 1'b1;
          cmd.clear = 1'b1;
          err_d     = pse_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::ST_IDLE;
      err_q       <= pse_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q  <= in_item_i.token;
      last_q <= in_item_i.last;
    end
    if (out_load) begin
      out_item_q.value  <= ((err_q == pse_pkg::STATUS_OK) && (count != '0)) ? tos : '0;
      out_item_q.status <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, in_ready_o && alu_stat.busy)
  `ASSERT_PROP(a_count_range, clk_i, rst_ni, count <= pse_pkg::CNT_FULL)
  `ASSERT_PROP(a_done_in_run, clk_i, rst_ni, alu_stat.done |-> (state_q == pse_pkg::ST_RUN))
  `ASSERT_PROP(a_load_free, clk_i, rst_ni, out_load |-> slot_free)

endmodule

### sim/postfix_stack_evaluator_tb.sv
// self-checking testbench for postfix_stack_evaluator: directed and random token streams
// are checked against a stack predictor kept in the testbench
// depends on pse_pkg and the postfix_stack_evaluator rtl
module postfix_stack_evaluator_tb;
  import pse_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int TAIL_CYCLES  = 80;
  localparam int LONG_HOLD    = 600;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [31:0] OPERAND_OFFSET = 32'd48;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pending_req_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_q = 1'b0;
  in_item_t  in_item_q = '0;
  logic      out_ready_q = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  pending_req_t pending_items[$];
  out_item_t    expected_results[$];
  pending_req_t next_req;
  bit           drain_next;

  // predictor state
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth;
  status_e     calc_err;

  int burst_left, gap_left;
  int hold_left, stall_phase;
  bit long_hold_done;
  int cycle_cnt, tokens_accepted, results_seen, mismatch_cnt;
  int status_tally [4];
  int expr_cnt;

  postfix_stack_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_op_byte(logic [7:0] tok);
    case (tok)
      TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_POW, TOK_REM: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] wrap_pow(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) return acc;
    while (ex != 32'd0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic void note_fault(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endfunction

  // advance the predictor by one accepted request
  task automatic apply_token(in_item_t it);
    logic [31:0] top, below, res, mag_t, mag_b;
    out_item_t   exp_item;
    if (calc_err == STATUS_OK) begin
      if (is_op_byte(it.token)) begin
        if (calc_depth < 2) begin
          calc_err = STATUS_UNDERFLOW;
        end else begin
          top   = calc_stack[calc_depth-1];
          below = calc_stack[calc_depth-2];
          if ((it.token == TOK_DIV || it.token == TOK_REM) && top == 32'd0) begin
            calc_err = STATUS_DIV_ZERO;
          end else begin
            // truncating signed divide done on magnitudes so min / -1 wraps
            mag_b = below[31] ? 32'd0 - below : below;
            mag_t = top[31] ? 32'd0 - top : top;
            case (it.token)
              TOK_ADD: res = below + top;
              TOK_SUB: res = below - top;
              TOK_MUL: res = below * top;
              TOK_DIV: begin
                res = mag_b / mag_t;
                if (below[31] != top[31]) res = 32'd0 - res;
              end
              TOK_REM: begin
                res = mag_b % mag_t;
                if (below[31]) res = 32'd0 - res;
              end
              default: res = wrap_pow(below, top);
            endcase
            calc_depth--;
            calc_stack[calc_depth-1] = res;
          end
        end
      end else if (calc_depth >= STACK_DEPTH) begin
        calc_err = STATUS_OVERFLOW;
      end else begin
        calc_stack[calc_depth] = {24'd0, it.token} - OPERAND_OFFSET;
        calc_depth++;
      end
    end
    if (it.last) begin
      exp_item.value  = (calc_err == STATUS_OK && calc_depth > 0) ?
                        calc_stack[calc_depth-1] : 32'd0;
      exp_item.status = calc_err;
      expected_results.push_back(exp_item);
      status_tally[calc_err]++;
      calc_depth = 0;
      calc_err   = STATUS_OK;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      note_fault($sformatf("unexpected result: value %0d status %0d",
                           got.value, got.status));
    end else begin
      want = expected_results.pop_front();
      if (got.value !== want.value)
        note_fault($sformatf("result %0d value: expected %0d, got %0d",
                             results_seen, want.value, got.value));
      if (got.status !== want.status)
        note_fault($sformatf("result %0d status: expected %0d, got %0d",
                             results_seen, want.status, got.status));
    end
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_item_q  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_q && in_ready_o) begin
        apply_token(in_item_q);
        tokens_accepted++;
      end
      if (!in_valid_q || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_q <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_results.size() != 0)) begin
          next_req = pending_items.pop_front();
          in_item_q  <= next_req.item;
          in_valid_q <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results, stalls on a phase pattern plus one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_q <= 1'b0;
      hold_left = 0;
      stall_phase = 0;
    end else begin
      if (out_valid_o && out_ready_q) check_result(out_item_o);
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      stall_phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_q <= 1'b0;
      end else begin
        case (stall_phase[9:8])
          2'd0: out_ready_q <= 1'b1;
          2'd1: out_ready_q <= ($urandom_range(0, 3) == 0);
          2'd2: out_ready_q <= $urandom_range(0, 1);
          default: out_ready_q <= (stall_phase[3:0] > 4'd9);
        endcase
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_item(logic [7:0] tok, bit last);
    pending_req_t req;
    req.item.token = tok;
    req.item.last  = last;
    req.drain      = drain_next;
    drain_next     = 1'b0;
    pending_items.push_back(req);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 5))
      0: return TOK_ADD;
      1: return TOK_SUB;
      2: return TOK_MUL;
      3: return TOK_DIV;
      4: return TOK_POW;
      default: return TOK_REM;
    endcase
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return CHAR_ZERO + 8'($urandom_range(0, 9));
    b = 8'($urandom_range(0, 255));
    while (is_op_byte(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // well-formed expression; deep puts every operand ahead of the operators
  task automatic build_expr(int n_ops, bit deep);
    int depth, operands_left, ops_left;
    logic [7:0] tok;
    depth = 0;
    operands_left = n_ops + 1;
    ops_left = n_ops;
    while (operands_left + ops_left > 0) begin
      if (operands_left > 0 && (depth < 2 || deep || $urandom_range(0, 1) == 0)) begin
        tok = pick_operand();
        depth++;
        operands_left--;
      end else begin
        tok = pick_operator();
        depth--;
        ops_left--;
      end
      queue_item(tok, operands_left + ops_left == 0);
    end
    expr_cnt++;
  endtask

  task automatic build_overflow();
    repeat (STACK_DEPTH + $urandom_range(1, 3)) queue_item(pick_operand(), 1'b0);
    repeat ($urandom_range(0, 3)) queue_item(pick_operator(), 1'b0);
    queue_item(8'($urandom_range(0, 255)), 1'b1);
    expr_cnt++;
  endtask

  initial begin
    int pick;
    // directed: extreme bytes, every operator, error cases
    queue_item(8'h00, 1'b0); queue_item(8'hFF, 1'b0); queue_item(TOK_ADD, 1'b1);
    queue_item("9", 1'b0); queue_item("3", 1'b0); queue_item(TOK_SUB, 1'b1);
    queue_item("7", 1'b0); queue_item("6", 1'b0); queue_item(TOK_MUL, 1'b1);
    // 2^31 gives the minimum, then divided by 0-1
    queue_item("2", 1'b0); queue_item("O", 1'b0); queue_item(TOK_POW, 1'b0);
    queue_item("0", 1'b0); queue_item("1", 1'b0); queue_item(TOK_SUB, 1'b0);
    queue_item(TOK_DIV, 1'b1);
    queue_item(TOK_ADD, 1'b1);
    queue_item("5", 1'b0); queue_item("0", 1'b0); queue_item(TOK_REM, 1'b1);
    // space is a negative exponent
    queue_item("2", 1'b0); queue_item(" ", 1'b0); queue_item(TOK_POW, 1'b1);
    queue_item("9", 1'b0); queue_item("4", 1'b0); queue_item(TOK_REM, 1'b1);

    drain_next = 1'b1;
    build_expr(STACK_DEPTH - 1, 1'b1);
    build_overflow();
    while (pending_items.size() < RANDOM_ITEMS) begin
      if (expr_cnt == 90) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        build_expr(STACK_DEPTH - 1, 1'b1);
      end else if (pick < 4) begin
        build_overflow();
      end else if (pick < 84) begin
        build_expr($urandom_range(1, 10), 1'b0);
      end else if (pick < 92) begin
        // operator with nothing stacked, rest of the expression is ignored
        queue_item(pick_operator(), 1'b0);
        build_expr($urandom_range(1, 6), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end
    end

    calc_depth = 0;
    calc_err = STATUS_OK;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_q || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_fault($sformatf("%0d expected results never arrived",
                           expected_results.size()));

    $display("run: %0d tokens accepted, %0d results checked, %0d mismatches",
             tokens_accepted, results_seen, mismatch_cnt);
    $display("statuses: %0d ok, %0d underflow, %0d divide by zero, %0d overflow",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/pse_pkg.sv
sv/pse_stack.sv
sv/pse_alu.sv
sv/postfix_stack_evaluator.sv
sim/postfix_stack_evaluator_tb.sv
